>>> src/tpt_pkg.sv
// tpt_pkg: shared types and codes for the transport port table
// no dependencies; imported by transport_port_table_unit
`timescale 1ns / 1ps

package tpt_pkg;

    localparam int PORT_W = 16;
    localparam int ID_W   = 6;

    localparam logic [PORT_W-1:0] MIN_PORT_RESET = 16'd32768;
    localparam logic [PORT_W-1:0] PORT_LAST      = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_BIND  = 2'd1,
        OP_FIND  = 2'd2,
        OP_CLOSE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_IN_USE   = 2'd2,
        ST_NOT_OPEN = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_RELEASE,
        S_PROBE,
        S_DONE
    } ctl_state_t;

    // port owner entry: owned flag plus socket id
    typedef struct packed {
        logic            owned;
        logic [ID_W-1:0] id;
    } own_entry_t;

    // socket entry: open flag plus bound port
    typedef struct packed {
        logic              open;
        logic [PORT_W-1:0] port;
    } sock_entry_t;

endpackage

>>> src/transport_port_table_unit.sv
// transport_port_table_unit: port to socket map with open, bind, find and close
// depends on tpt_pkg (types, opcodes, status codes)
`timescale 1ns / 1ps

// channel   direction  handshake              contents
// in        input      in_valid / in_ready    opcode, socket_id, port
// out       output     out_valid / out_ready  status, result_port, found, owner_id
// cfg       input      cfg_we                 cfg_wdata -> min_client_port
//
// one word at a time: find, bind no-ops and requests refused at lookup go from
// lookup to the done step; close and a moving bind also pass the release step;
// open probes past each owned port (one port owner memory read per cycle)
// after reset a clearing pass writes every port owner entry with in_ready low;
// cfg writes are taken during it
// a finished word waits in the output register, so the next word is accepted
// while out_ready is low; a second result then holds until the register frees

module transport_port_table_unit #(
    parameter int SOCKETS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [tpt_pkg::PORT_W-1:0]        cfg_wdata,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic [tpt_pkg::ID_W-1:0]          socket_id,
    input  logic [tpt_pkg::PORT_W-1:0]        port,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output tpt_pkg::status_t                  status,
    output logic [tpt_pkg::PORT_W-1:0]        result_port,
    output logic                              found,
    output logic [tpt_pkg::ID_W-1:0]          owner_id
);

    import tpt_pkg::*;

    localparam int SK_AW     = $clog2(SOCKETS);
    localparam int OWN_DEPTH = 1 << PORT_W;

    // memories
    own_entry_t  own_mem  [OWN_DEPTH];
    sock_entry_t sock_mem [SOCKETS];

    logic              own_we;
    logic [PORT_W-1:0] own_waddr;
    own_entry_t        own_wdata;
    logic [PORT_W-1:0] own_raddr;
    own_entry_t        own_rd;

    logic              sock_we;
    logic [SK_AW-1:0]  sock_waddr;
    sock_entry_t       sock_wdata;
    logic [SK_AW-1:0]  sock_raddr;
    sock_entry_t       sock_rd;

    // control state
    ctl_state_t        state_reg, state_next;
    logic [PORT_W-1:0] cnt_reg, cnt_next;           // clear sweep or probe count
    logic [PORT_W-1:0] next_port_reg, next_port_next;
    logic [PORT_W-1:0] min_port_reg;
    logic              out_valid_reg, out_valid_next;

    // request and working payload
    op_t               op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic [PORT_W-1:0] cand_reg, cand_next;
    logic [PORT_W-1:0] cur_reg, cur_next;

    // pending result and output register
    status_t           res_status_reg, res_status_next;
    logic [PORT_W-1:0] res_port_reg, res_port_next;
    logic              res_found_reg, res_found_next;
    logic [ID_W-1:0]   res_owner_reg, res_owner_next;
    logic              out_load;
    status_t           out_status_reg;
    logic [PORT_W-1:0] out_port_reg;
    logic              out_found_reg;
    logic [ID_W-1:0]   out_owner_reg;

    logic              id_ok;
    logic              is_open;
    logic [PORT_W-1:0] open_start;
    logic [PORT_W-1:0] cand_step;
    logic [PORT_W-1:0] cand_wrap;

    // ids past the socket count behave as never open
    assign id_ok   = (32'(id_reg) < SOCKETS);
    assign is_open = id_ok && sock_rd.open;

    // counter clamp at the bottom of the client range
    assign open_start = (next_port_reg < min_port_reg) ? min_port_reg : next_port_reg;
    assign cand_wrap  = cand_reg + 16'd1;
    assign cand_step  = (cand_wrap < min_port_reg) ? min_port_reg : cand_wrap;

    // port owner memory, read-before-write, registered read
    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            own_mem[own_waddr] <= own_wdata;
        end
        own_rd <= own_mem[own_raddr];
    end

    // socket memory
    always_ff @(posedge clk)
    begin
        if (sock_we)
        begin
            sock_mem[sock_waddr] <= sock_wdata;
        end
        sock_rd <= sock_mem[sock_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            next_port_reg <= '0;
            min_port_reg  <= MIN_PORT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            next_port_reg <= next_port_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                min_port_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        port_reg       <= port_next;
        cand_reg       <= cand_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_port_reg   <= res_port_next;
        res_found_reg  <= res_found_next;
        res_owner_reg  <= res_owner_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_port_reg   <= res_port_reg;
            out_found_reg  <= res_found_reg;
            out_owner_reg  <= res_owner_reg;
        end
    end

    // sequencer: next state, memory accesses, result
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        next_port_next  = next_port_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        port_next       = port_reg;
        cand_next       = cand_reg;
        cur_next        = cur_reg;
        res_status_next = res_status_reg;
        res_port_next   = res_port_reg;
        res_found_next  = res_found_reg;
        res_owner_next  = res_owner_reg;
        out_load        = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        in_ready        = 1'b0;

        own_we     = 1'b0;
        own_waddr  = port_reg;
        own_wdata  = '0;
        own_raddr  = port_reg;
        sock_we    = 1'b0;
        sock_waddr = SK_AW'(id_reg);
        sock_wdata = '0;
        sock_raddr = SK_AW'(id_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                // one port entry per cycle, socket entries ride along
                own_we    = 1'b1;
                own_waddr = cnt_reg;
                if (32'(cnt_reg) < SOCKETS)
                begin
                    sock_we    = 1'b1;
                    sock_waddr = cnt_reg[SK_AW-1:0];
                end
                cnt_next = cnt_reg + 16'd1;
                if (cnt_reg == PORT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ready   = 1'b1;
                own_raddr  = port;
                sock_raddr = SK_AW'(socket_id);
                if (in_valid)
                begin
                    op_next    = op_t'(opcode);
                    id_next    = socket_id;
                    port_next  = port;
                    state_next = S_LOOKUP;
                end
            end

            S_LOOKUP:
            begin
                // socket entry and owner of the request port are here now
                res_status_next = ST_OK;
                res_port_next   = '0;
                res_found_next  = 1'b0;
                res_owner_next  = '0;
                state_next      = S_DONE;
                unique case (op_reg)
                    OP_OPEN:
                    begin
                        if (!id_ok || sock_rd.open)
                        begin
                            res_status_next = ST_NOT_OPEN;
                        end
                        else
                        begin
                            own_raddr  = open_start;
                            cand_next  = open_start;
                            cnt_next   = '0;
                            state_next = S_PROBE;
                        end
                    end

                    OP_BIND:
                    begin
                        if (!is_open)
                        begin
                            res_status_next = ST_NOT_OPEN;
                        end
                        else
                        begin
                            res_port_next = sock_rd.port;
                            priority if (port_reg == '0)
                            begin
                                res_status_next = ST_OK;
                            end
                            else if (port_reg >= min_port_reg)
                            begin
                                res_status_next = ST_INVALID;
                            end
                            else if (own_rd.owned)
                            begin
                                if (own_rd.id != id_reg)
                                begin
                                    res_status_next = ST_IN_USE;
                                end
                            end
                            else
                            begin
                                // take the new port, release the old one next
                                own_we           = 1'b1;
                                own_waddr        = port_reg;
                                own_wdata.owned  = 1'b1;
                                own_wdata.id     = id_reg;
                                sock_we          = 1'b1;
                                sock_wdata.open  = 1'b1;
                                sock_wdata.port  = port_reg;
                                res_port_next    = port_reg;
                                cur_next         = sock_rd.port;
                                own_raddr        = sock_rd.port;
                                state_next       = S_RELEASE;
                            end
                        end
                    end

                    OP_FIND:
                    begin
                        res_found_next = own_rd.owned;
                        res_owner_next = own_rd.owned ? own_rd.id : '0;
                    end

                    OP_CLOSE:
                    begin
                        if (!is_open)
                        begin
                            res_status_next = ST_NOT_OPEN;
                        end
                        else
                        begin
                            res_port_next = sock_rd.port;
                            sock_we       = 1'b1;
                            cur_next      = sock_rd.port;
                            own_raddr     = sock_rd.port;
                            state_next    = S_RELEASE;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_RELEASE:
            begin
                // free the old port only if this socket still owns it
                if (own_rd.owned && (own_rd.id == id_reg))
                begin
                    own_we    = 1'b1;
                    own_waddr = cur_reg;
                end
                state_next = S_DONE;
            end

            S_PROBE:
            begin
                if (!own_rd.owned)
                begin
                    own_we          = 1'b1;
                    own_waddr       = cand_reg;
                    own_wdata.owned = 1'b1;
                    own_wdata.id    = id_reg;
                    sock_we         = 1'b1;
                    sock_wdata.open = 1'b1;
                    sock_wdata.port = cand_reg;
                    next_port_next  = cand_wrap;
                    res_port_next   = cand_reg;
                    state_next      = S_DONE;
                end
                else if (cnt_reg == PORT_LAST)
                begin
                    // whole client port range swept, nothing free
                    res_status_next = ST_IN_USE;
                    state_next      = S_DONE;
                end
                else
                begin
                    cnt_next  = cnt_reg + 16'd1;
                    cand_next = cand_step;
                    own_raddr = cand_step;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign result_port = out_port_reg;
    assign found       = out_found_reg;
    assign owner_id    = out_owner_reg;

    // probes never go below the client range
    a_probe_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (cand_reg >= min_port_reg))
        else $error("probe candidate below min_client_port");

    // an accepted word goes straight to its lookup
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_LOOKUP))
        else $error("accepted word did not start a lookup");

    // no table writes while waiting for a request or a free output slot
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) || (state_reg == S_DONE)) |-> (!own_we && !sock_we))
        else $error("table written outside an operation");

    // a delivered word without an owner carries no owner id
    a_owner_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (owner_id == '0))
        else $error("owner id set without an owner");

    // a result is loaded only after the operation has finished
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded outside the done step");

endmodule
